FILE: hdl/acd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII command decoder package
// Shared types and character constants for the text command decoder.
// ----------------------------------------------------------------------------
package acd_pkg;

    // Largest number of decimal digits taken after a B command.
    localparam logic [1:0] MAX_DIGITS = 2'd3;

    // Command characters.
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_FOUR = 8'h34;

    // Parser mode, one-hot.
    typedef enum logic [5:0] {
        MODE_IDLE   = 6'b000001,
        MODE_LED    = 6'b000010,
        MODE_LEDNUM = 6'b000100,
        MODE_SWITCH = 6'b001000,
        MODE_BUZZ   = 6'b010000,
        MODE_ERR    = 6'b100000
    } t_mode;

    typedef enum logic [1:0] {
        LED_CLEAR  = 2'd0,
        LED_SET    = 2'd1,
        LED_REPORT = 2'd2
    } t_led_act;

    typedef enum logic [2:0] {
        RESP_NONE = 3'd0,
        RESP_ACK  = 3'd1,
        RESP_ON   = 3'd2,
        RESP_OFF  = 3'd3,
        RESP_ERR  = 3'd4
    } t_resp;

    // Parser state carried from one byte to the next.
    typedef struct packed {
        t_mode       mode;
        t_led_act    led_action;
        logic [1:0]  digit_count;
        logic [9:0]  ms_accum;
        logic [3:0]  led_bits;
    } t_state;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [3:0] switch_levels;
    } t_in_item;

    typedef struct packed {
        logic [2:0] resp;
        logic [3:0] led_levels;
        logic       buzz_start;
        logic [9:0] buzz_ms;
    } t_out_item;

endpackage
`default_nettype wire

FILE: hdl/acd_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII command decoder step
// Decodes one byte against the current parser state and forms the response.
// ----------------------------------------------------------------------------
module acd_step (
    input  acd_pkg::t_state    i_state,
    input  acd_pkg::t_in_item  i_item,
    output acd_pkg::t_state    o_state,
    output acd_pkg::t_out_item o_item
);
    import acd_pkg::*;

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0D, 8'h0A, 8'h00};
    endfunction

    // Mode entered when a byte starts a new command.
    function automatic t_mode idle_mode(input logic [7:0] c);
        t_mode m;
        if (c == CH_L) begin
            m = MODE_LED;
        end else if (c == CH_S) begin
            m = MODE_SWITCH;
        end else if (c == CH_B) begin
            m = MODE_BUZZ;
        end else if (is_blank(c)) begin
            m = MODE_IDLE;
        end else begin
            m = MODE_ERR;
        end
        return m;
    endfunction

    logic [7:0]  ch;
    logic        is_digit;
    logic        is_num;
    logic [3:0]  sel_bit;
    logic [1:0]  sel_idx;
    logic [13:0] ms_wide;
    logic [9:0]  ms_next;
    logic [1:0]  cnt_next;
    t_state      nx;
    t_resp       resp;
    logic        bstart;
    logic [9:0]  bms;

    assign ch       = i_item.ch;
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_num   = (ch >= CH_ONE) && (ch <= CH_FOUR);
    assign sel_idx  = 2'(ch[2:0] - 3'd1);
    assign sel_bit  = 4'b0001 << sel_idx;
    // ms_accum * 10 + digit, kept to ten bits.
    assign ms_wide  = {1'b0, i_state.ms_accum, 3'b000} + {3'b000, i_state.ms_accum, 1'b0}
                    + {10'd0, ch[3:0]};
    assign ms_next  = ms_wide[9:0];
    assign cnt_next = i_state.digit_count + 2'd1;

    always_comb begin
        nx     = i_state;
        resp   = RESP_NONE;
        bstart = 1'b0;
        bms    = '0;
        case (i_state.mode)
            MODE_LED: begin
                if (ch == CH_C) begin
                    nx.led_action = LED_CLEAR;
                    nx.mode       = MODE_LEDNUM;
                end else if (ch == CH_S) begin
                    nx.led_action = LED_SET;
                    nx.mode       = MODE_LEDNUM;
                end else if (ch == CH_R) begin
                    nx.led_action = LED_REPORT;
                    nx.mode       = MODE_LEDNUM;
                end else begin
                    nx.mode = MODE_ERR;
                end
            end
            MODE_LEDNUM: begin
                if (is_num) begin
                    case (i_state.led_action)
                        LED_CLEAR: begin
                            nx.led_bits = i_state.led_bits & ~sel_bit;
                            resp        = RESP_ACK;
                        end
                        LED_SET: begin
                            nx.led_bits = i_state.led_bits | sel_bit;
                            resp        = RESP_ACK;
                        end
                        default: begin
                            resp = ((i_state.led_bits & sel_bit) != 4'd0) ? RESP_ON : RESP_OFF;
                        end
                    endcase
                    nx.mode        = MODE_IDLE;
                    nx.led_action  = LED_CLEAR;
                    nx.digit_count = '0;
                    nx.ms_accum    = '0;
                end else begin
                    nx.mode = MODE_ERR;
                end
            end
            MODE_SWITCH: begin
                if (is_num) begin
                    resp = ((i_item.switch_levels & sel_bit) != 4'd0) ? RESP_ON : RESP_OFF;
                    nx.mode = MODE_IDLE;
                end else begin
                    nx.mode = MODE_ERR;
                end
            end
            MODE_BUZZ: begin
                if (is_digit) begin
                    nx.ms_accum    = ms_next;
                    nx.digit_count = cnt_next;
                    if (cnt_next >= MAX_DIGITS) begin
                        resp           = RESP_ACK;
                        bstart         = 1'b1;
                        bms            = ms_next;
                        nx.mode        = MODE_IDLE;
                        nx.led_action  = LED_CLEAR;
                        nx.digit_count = '0;
                        nx.ms_accum    = '0;
                    end
                end else if (i_state.digit_count != 2'd0) begin
                    // The number ends here; the byte itself starts the next command.
                    resp           = RESP_ACK;
                    bstart         = 1'b1;
                    bms            = i_state.ms_accum;
                    nx.led_action  = LED_CLEAR;
                    nx.digit_count = '0;
                    nx.ms_accum    = '0;
                    nx.mode        = idle_mode(ch);
                end else if (is_blank(ch)) begin
                    resp    = RESP_ERR;
                    nx.mode = MODE_IDLE;
                end else begin
                    nx.mode = MODE_ERR;
                end
            end
            MODE_ERR: begin
                if (is_blank(ch)) begin
                    resp    = RESP_ERR;
                    nx.mode = MODE_IDLE;
                end
            end
            default: begin
                nx.mode = idle_mode(ch);
            end
        endcase

        // End of buffer: finish pending digits, report a pending error, drop the rest.
        if (i_item.last) begin
            if ((nx.mode == MODE_BUZZ) && (nx.digit_count != 2'd0)) begin
                resp   = RESP_ACK;
                bstart = 1'b1;
                bms    = nx.ms_accum;
            end else if ((nx.mode == MODE_ERR) && (resp == RESP_NONE)) begin
                resp = RESP_ERR;
            end
            nx.mode        = MODE_IDLE;
            nx.led_action  = LED_CLEAR;
            nx.digit_count = '0;
            nx.ms_accum    = '0;
        end
    end

    assign o_state           = nx;
    assign o_item.resp       = resp;
    assign o_item.led_levels = nx.led_bits;
    assign o_item.buzz_start = bstart;
    assign o_item.buzz_ms    = bms;

endmodule
`default_nettype wire

FILE: hdl/ascii_command_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ASCII command decoder
// Text command parser for LED, switch and buzzer, one byte a cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes arrive on the input channel (i_in_valid / o_in_stall / i_in_item);
//   a transaction completes at a rising edge with valid high and stall low.
//   Every byte yields exactly one result transaction on the output channel
//   (o_out_valid / i_out_stall / o_out_item), in order. resp is zero when the
//   byte completes nothing; led_levels always shows the kept LED bits.
//   The byte is captured in the input register when it is accepted and the
//   decoded result is registered once the result register can take it.
//   Throughput is one byte per cycle while the output does not stall. The
//   parser state feeds back through a single decode step between the input
//   register and the result register, and that loop sets the rate.
//   While the receiver stalls, the result register holds its transaction and
//   the input register holds the next byte; once both are full, o_in_stall
//   rises and no further byte is accepted until the output moves.
//   Reset puts the parser in idle, clears the pending command and turns all
//   kept LED bits off; both channels come out of reset empty.
// ----------------------------------------------------------------------------
module ascii_command_decoder_top (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  acd_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output acd_pkg::t_out_item  o_out_item
);
    import acd_pkg::*;

    // Input register.
    logic      r_in_valid;
    t_in_item  r_in;

    // Parser state, advanced once per decoded byte.
    t_state    r_state;
    t_state    n_state;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    logic      out_adv;
    logic      fire;

    // The result register can take a new transaction when empty or draining.
    assign out_adv    = !r_out_valid || !i_out_stall;
    // A byte is decoded in the cycle it moves from the input to the result register.
    assign fire       = r_in_valid && out_adv;
    assign o_in_stall = r_in_valid && !out_adv;

    acd_step u_step (
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state),
        .o_item  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode        <= MODE_IDLE;
            r_state.led_action  <= LED_CLEAR;
            r_state.digit_count <= '0;
            r_state.ms_accum    <= '0;
            r_state.led_bits    <= '0;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // A buffered byte that is not held back always produces a result next cycle.
    a_fire_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("decoded byte did not reach the result register");

    // Buzzer digits are only pending while a B command is open.
    a_digits_in_buzz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state.digit_count != 2'd0) || (r_state.ms_accum != 10'd0))
        |-> (r_state.mode == MODE_BUZZ))
        else $error("buzzer digits pending outside a B command");

    // A buzzer start is always acknowledged, and a duration only comes with a start.
    a_buzz_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.buzz_start) |-> (o_out_item.resp == RESP_ACK))
        else $error("buzzer start without ACK");

    a_buzz_ms_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.buzz_start) |-> (o_out_item.buzz_ms == 10'd0))
        else $error("buzzer duration without a start");
`endif

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ASCII command decoder testbench
// Drives byte streams of LED, switch and buzzer commands with random pacing,
// predicts each result transaction and checks it field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import acd_pkg::*;

    // Blank characters that separate commands.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HALF_TARGET   = 650;
    localparam int MAX_PRINTED   = 50;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_item   in_item = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_item;

    // Bytes waiting to be driven, and results predicted for accepted bytes.
    t_in_item   pending_bytes[$];
    t_out_item  expected_results[$];

    int errors = 0;
    int cycle_count = 0;

    // Shadow of the parser state, updated once per accepted byte.
    t_mode      pm_mode = MODE_IDLE;
    t_led_act   pm_act = LED_CLEAR;
    logic [1:0] pm_digits = '0;
    logic [9:0] pm_ms = '0;
    logic [3:0] pm_leds = '0;

    ascii_command_decoder_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hung handshake must not run forever.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL ascii_command_decoder_top");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (errors < MAX_PRINTED) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
        errors++;
    endtask

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_NUL;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Mode entered when a byte is parsed from idle.
    function automatic t_mode idle_next(input logic [7:0] c);
        if (c == CH_L) begin
            return MODE_LED;
        end else if (c == CH_S) begin
            return MODE_SWITCH;
        end else if (c == CH_B) begin
            return MODE_BUZZ;
        end else if (is_blank(c)) begin
            return MODE_IDLE;
        end
        return MODE_ERR;
    endfunction

    // Advances the shadow parser by one byte and returns the result it
    // should produce.
    function automatic t_out_item decode_byte(input t_in_item it);
        t_out_item  res;
        logic [7:0] c;
        logic [3:0] bitm;
        t_resp      resp;
        c = it.ch;
        resp = RESP_NONE;
        res = '0;
        bitm = 4'b0001 << (c - CH_ONE);
        case (pm_mode)
            MODE_LED: begin
                if (c == CH_C) begin
                    pm_act = LED_CLEAR;
                    pm_mode = MODE_LEDNUM;
                end else if (c == CH_S) begin
                    pm_act = LED_SET;
                    pm_mode = MODE_LEDNUM;
                end else if (c == CH_R) begin
                    pm_act = LED_REPORT;
                    pm_mode = MODE_LEDNUM;
                end else begin
                    pm_mode = MODE_ERR;
                end
            end
            MODE_LEDNUM: begin
                if (c >= CH_ONE && c <= CH_FOUR) begin
                    if (pm_act == LED_CLEAR) begin
                        pm_leds = pm_leds & ~bitm;
                        resp = RESP_ACK;
                    end else if (pm_act == LED_SET) begin
                        pm_leds = pm_leds | bitm;
                        resp = RESP_ACK;
                    end else if ((pm_leds & bitm) != 0) begin
                        resp = RESP_ON;
                    end else begin
                        resp = RESP_OFF;
                    end
                    pm_mode = MODE_IDLE;
                    pm_act = LED_CLEAR;
                    pm_digits = '0;
                    pm_ms = '0;
                end else begin
                    pm_mode = MODE_ERR;
                end
            end
            MODE_SWITCH: begin
                if (c >= CH_ONE && c <= CH_FOUR) begin
                    if ((it.switch_levels & bitm) != 0) begin
                        resp = RESP_ON;
                    end else begin
                        resp = RESP_OFF;
                    end
                    pm_mode = MODE_IDLE;
                end else begin
                    pm_mode = MODE_ERR;
                end
            end
            MODE_BUZZ: begin
                if (is_digit(c)) begin
                    pm_ms = 10'((pm_ms * 10) + (c - CH_ZERO));
                    pm_digits = pm_digits + 2'd1;
                    if (pm_digits >= MAX_DIGITS) begin
                        resp = RESP_ACK;
                        res.buzz_start = 1'b1;
                        res.buzz_ms = pm_ms;
                        pm_mode = MODE_IDLE;
                        pm_act = LED_CLEAR;
                        pm_digits = '0;
                        pm_ms = '0;
                    end
                end else if (pm_digits != 0) begin
                    // A non-digit closes the number and is then parsed anew.
                    resp = RESP_ACK;
                    res.buzz_start = 1'b1;
                    res.buzz_ms = pm_ms;
                    pm_act = LED_CLEAR;
                    pm_digits = '0;
                    pm_ms = '0;
                    pm_mode = idle_next(c);
                end else if (is_blank(c)) begin
                    resp = RESP_ERR;
                    pm_mode = MODE_IDLE;
                end else begin
                    pm_mode = MODE_ERR;
                end
            end
            MODE_ERR: begin
                if (is_blank(c)) begin
                    resp = RESP_ERR;
                    pm_mode = MODE_IDLE;
                end
            end
            default: begin
                pm_mode = idle_next(c);
            end
        endcase
        // The end of a buffer flushes whatever command is still open.
        if (it.last) begin
            if (pm_mode == MODE_BUZZ && pm_digits != 0) begin
                resp = RESP_ACK;
                res.buzz_start = 1'b1;
                res.buzz_ms = pm_ms;
            end else if (pm_mode == MODE_ERR && resp == RESP_NONE) begin
                resp = RESP_ERR;
            end
            pm_mode = MODE_IDLE;
            pm_act = LED_CLEAR;
            pm_digits = '0;
            pm_ms = '0;
        end
        res.resp = resp;
        res.led_levels = pm_leds;
        return res;
    endfunction

    // Sender: bursts of random length separated by random gaps. A stalled
    // transaction is held unchanged until it is accepted.
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_results.push_back(decode_byte(in_item));
            end
            if (!(in_valid && in_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    in_item <= pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 60);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern switches between free flow, light random
    // stalls and heavy stalls, picked anew at random times.
    int stall_mode = 0;
    int stall_phase = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (stall_phase == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_phase = $urandom_range(50, 300);
            end else begin
                stall_phase--;
            end
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 2) == 0);
                default: out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Monitor: every accepted result transaction is checked against the
    // oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", out_item));
            end else begin
                want = expected_results.pop_front();
                if (out_item.resp !== want.resp) begin
                    report_mismatch($sformatf("resp %0d, want %0d", out_item.resp, want.resp));
                end
                if (out_item.led_levels !== want.led_levels) begin
                    report_mismatch($sformatf("led_levels %b, want %b",
                                              out_item.led_levels, want.led_levels));
                end
                if (out_item.buzz_start !== want.buzz_start) begin
                    report_mismatch($sformatf("buzz_start %b, want %b",
                                              out_item.buzz_start, want.buzz_start));
                end
                if (out_item.buzz_ms !== want.buzz_ms) begin
                    report_mismatch($sformatf("buzz_ms %0d, want %0d",
                                              out_item.buzz_ms, want.buzz_ms));
                end
            end
        end
    end

    task automatic push_byte(input logic [7:0] c, input logic lst, input logic [3:0] sw);
        t_in_item it;
        it.ch = c;
        it.last = lst;
        it.switch_levels = sw;
        pending_bytes.push_back(it);
    endtask

    task automatic push_plain(input logic [7:0] c);
        push_byte(c, 1'b0, 4'($urandom));
    endtask

    function automatic logic [7:0] any_blank();
        case ($urandom_range(0, 4))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_CR;
            3: return CH_LF;
            default: return CH_NUL;
        endcase
    endfunction

    // Queues one random command: mostly well formed with random content,
    // sometimes corrupted, sometimes plain noise. Returns the number of
    // bytes queued, separators included.
    task automatic add_command(output int count);
        logic [7:0] seq[$];
        int kind;
        int n;
        int i;
        logic lst;
        kind = $urandom_range(0, 15);
        if (kind <= 4) begin
            seq.push_back(CH_L);
            case ($urandom_range(0, 2))
                0: seq.push_back(CH_C);
                1: seq.push_back(CH_S);
                default: seq.push_back(CH_R);
            endcase
            seq.push_back(CH_ONE + 8'($urandom_range(0, 3)));
        end else if (kind <= 7) begin
            seq.push_back(CH_S);
            seq.push_back(CH_ONE + 8'($urandom_range(0, 3)));
        end else if (kind <= 11) begin
            seq.push_back(CH_B);
            n = (kind == 11) ? $urandom_range(0, 4) : $urandom_range(1, 3);
            for (i = 0; i < n; i++) begin
                seq.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
        end else begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) begin
                seq.push_back(8'($urandom));
            end
        end
        // Broken sequences: one byte replaced by anything at all.
        if ($urandom_range(0, 7) == 0) begin
            seq[$urandom_range(0, seq.size() - 1)] = 8'($urandom);
        end
        n = $urandom_range(0, 2);
        for (i = 0; i < n; i++) begin
            seq.push_back(any_blank());
        end
        count = seq.size();
        lst = ($urandom_range(0, 5) == 0);
        for (i = 0; i < seq.size(); i++) begin
            push_byte(seq[i], (lst && i == seq.size() - 1) || ($urandom_range(0, 49) == 0),
                      4'($urandom));
        end
    endtask

    task automatic add_random_part(input int target);
        int total;
        int n;
        total = 0;
        while (total < target) begin
            add_command(n);
            total += n;
        end
    endtask

    // Holds until every queued byte is accepted and every result has come.
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed commands: set, report on and off, clear, switch report,
        // largest buzzer value, buzzer closed by the end of a buffer, an
        // invalid byte followed by a blank, and B followed directly by a blank.
        push_plain(CH_L); push_plain(CH_S); push_plain(CH_ONE);
        push_plain(CH_L); push_plain(CH_R); push_plain(CH_ONE);
        push_plain(CH_L); push_plain(CH_R); push_plain(CH_FOUR);
        push_plain(CH_L); push_plain(CH_C); push_plain(CH_ONE);
        push_byte(CH_S, 1'b0, 4'b1000); push_byte(CH_FOUR, 1'b0, 4'b1000);
        push_plain(CH_B); push_plain(CH_NINE); push_plain(CH_NINE); push_plain(CH_NINE);
        push_plain(CH_B); push_byte(CH_ZERO, 1'b1, 4'b0000);
        push_plain(8'hFF); push_plain(CH_TAB);
        push_plain(CH_B); push_plain(CH_NUL);
        wait_drained();

        // Random traffic in two halves, with a full drain in between.
        add_random_part(HALF_TARGET);
        wait_drained();
        add_random_part(HALF_TARGET);
        wait_drained();

        // Give a stray extra result time to show up.
        repeat (10) @(negedge i_clk);
        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end
        if (errors == 0) begin
            $display("PASS ascii_command_decoder_top");
        end else begin
            $display("FAIL ascii_command_decoder_top");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/acd_pkg.sv
hdl/acd_step.sv
hdl/ascii_command_decoder_top.sv
sim/tb_top.sv
